[hdl/bzf_pkg.sv]
// bzf_pkg: shared constants and types for the cubic bezier flattener
// used by bzf_flat and cubic_bezier_adaptive_flatten
`timescale 1ns / 1ps

package bzf_pkg;

    // external field widths
    localparam int COORD_W = 24;
    localparam int TOL_W   = 16;
    localparam int NCOORD  = 8;
    localparam int IN_W    = NCOORD * COORD_W;
    localparam int OUT_W   = 2 * COORD_W;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd64;

    // parameter defaults
    localparam int MAX_DEPTH_DEF  = 5;
    localparam int GUARD_BITS_DEF = 8;

    // squares of clamped magnitudes and their sums
    localparam int MAG_W = 31;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 1;

    // flatness unit status
    typedef struct packed {
        logic done;
        logic flat;
    } bzf_flat_st_t;

endpackage

[hdl/bzf_stack.sv]
// bzf_stack: row memory holding the pending right halves and their levels
// one write port, one read port with registered read data; no package use
`timescale 1ns / 1ps

module bzf_stack #(
    parameter int DEPTH = 5,
    parameter int AW    = 3,
    parameter int DW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bzf_flat.sv]
// bzf_flat: flatness test of one curve piece on one squarer
// depends on bzf_pkg (widths, status struct)
`timescale 1ns / 1ps

module bzf_flat #(
    parameter int CW = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [bzf_pkg::TOL_W-1:0]       tol,
    input  logic signed [CW-1:0]            coord [bzf_pkg::NCOORD],
    output bzf_pkg::bzf_flat_st_t           status
);
    import bzf_pkg::*;

    localparam int GB    = CW - COORD_W;
    localparam int LIN_W = CW + 3;
    localparam logic [63:0] CLAMP_MAX = 64'h7FFF_FFFF;

    // phase codes: the lin, square and accumulate stages are pipelined through lin_reg and mul_reg
    localparam logic [2:0] PH_TOL  = 3'd0;
    localparam logic [2:0] PH_LUX  = 3'd1;
    localparam logic [2:0] PH_LVX  = 3'd2;
    localparam logic [2:0] PH_LUY  = 3'd3;
    localparam logic [2:0] PH_LVY  = 3'd4;
    localparam logic [2:0] PH_SVY  = 3'd6;
    localparam logic [2:0] PH_DONE = 3'd7;

    // accumulate stage view of the same phases
    localparam logic [2:0] PH_ATOL = 3'd2;
    localparam logic [2:0] PH_AUX  = 3'd3;
    localparam logic [2:0] PH_AVX  = 3'd4;
    localparam logic [2:0] PH_AUY  = 3'd5;

    logic                     run_reg, run_next;
    logic [2:0]               phase_reg, phase_next;
    logic signed [LIN_W-1:0]  lin_reg, lin_next;
    logic [SQ_W-1:0]          mul_reg, mul_next;
    logic [SUM_W-1:0]         thr_reg, thr_next;
    logic [SQ_W-1:0]          mx_reg, mx_next;
    logic [SQ_W-1:0]          sx_reg, sx_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [LIN_W-1:0]         mag;
    logic [63:0]              mag64;
    logic [MAG_W-1:0]         sq_in;
    logic [SQ_W-1:0]          max_cur;

    function automatic logic signed [LIN_W-1:0] lin3(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b,
        input logic signed [CW-1:0] c
    );
        logic signed [LIN_W-1:0] ea, eb, ec;
        ea = LIN_W'(a);
        eb = LIN_W'(b);
        ec = LIN_W'(c);
        return (ea <<< 1) + ea - (eb <<< 1) - ec;
    endfunction

    // lin stage: 3a - 2b - c per component, tolerance first
    always_comb begin
        unique case (phase_reg)
            PH_TOL:  lin_next = LIN_W'($signed({1'b0, tol}));
            PH_LUX:  lin_next = lin3(coord[2], coord[0], coord[6]);
            PH_LVX:  lin_next = lin3(coord[4], coord[6], coord[0]);
            PH_LUY:  lin_next = lin3(coord[3], coord[1], coord[7]);
            PH_LVY:  lin_next = lin3(coord[5], coord[7], coord[1]);
            default: lin_next = lin_reg;
        endcase
    end

    // square stage with magnitude clamp
    always_comb begin
        mag      = lin_reg[LIN_W-1] ? LIN_W'(-lin_reg) : LIN_W'(lin_reg);
        mag64    = 64'(mag);
        sq_in    = (mag64 > CLAMP_MAX) ? CLAMP_MAX[MAG_W-1:0] : mag64[MAG_W-1:0];
        mul_next = SQ_W'(sq_in) * SQ_W'(sq_in);
    end

    // accumulate stage: max within an axis, sum over axes
    always_comb begin
        max_cur  = (mul_reg > mx_reg) ? mul_reg : mx_reg;
        thr_next = thr_reg;
        mx_next  = mx_reg;
        sx_next  = sx_reg;
        sum_next = sum_reg;
        unique case (phase_reg)
            PH_ATOL: thr_next = {1'b0, mul_reg} << (4 + 2 * GB);
            PH_AUX:  mx_next  = mul_reg;
            PH_AVX:  sx_next  = max_cur;
            PH_AUY:  mx_next  = mul_reg;
            PH_SVY:  sum_next = {1'b0, sx_reg} + {1'b0, max_cur};
            default: ;
        endcase
    end

    always_comb begin
        run_next   = run_reg;
        phase_next = phase_reg;
        if (start) begin
            run_next   = 1'b1;
            phase_next = '0;
        end else if (run_reg) begin
            phase_next = phase_reg + 3'd1;
            if (phase_reg == PH_DONE) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            phase_reg <= '0;
        end else begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        lin_reg <= lin_next;
        mul_reg <= mul_next;
        thr_reg <= thr_next;
        mx_reg  <= mx_next;
        sx_reg  <= sx_next;
        sum_reg <= sum_next;
    end

    assign status.done = run_reg && (phase_reg == PH_DONE);
    assign status.flat = (sum_reg <= thr_reg);

endmodule

[hdl/cubic_bezier_adaptive_flatten.sv]
// cubic_bezier_adaptive_flatten: adaptive subdivision of one cubic curve into a polyline
// depends on bzf_pkg, bzf_stack (pending halves) and bzf_flat (flatness test)
//
//  channel   | dir | beat contents
//  ----------+-----+--------------------------------------------------------------
//  s_axis    | in  | one curve: four control points, Q15.8
//  m_axis    | out | one polyline vertex, tlast on the final vertex of a curve
//  cfg       | in  | tolerance, Q8.8, written whenever cfg_wen is high
//
// walk: a tested node issues in ST_NODE and waits in ST_TEST on the flatness unit; a node at the
//   depth bound goes straight to ST_FLAT; either then emits its end point and, with the stack not
//   empty, pops in ST_POPW; a split node runs ST_SPLIT (six midpoints per axis on one adder)
//   and then pushes in ST_PUSH.
// reset: synchronous active low aresetn; tolerance returns to 0.25.
// stalls: s_tready only between curves; a waiting vertex holds the walk at its next emit
`timescale 1ns / 1ps

module cubic_bezier_adaptive_flatten #(
    parameter int MAX_DEPTH  = bzf_pkg::MAX_DEPTH_DEF,
    parameter int GUARD_BITS = bzf_pkg::GUARD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    input  logic [bzf_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // point_x, point_y
    output logic [bzf_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_wen,
    input  logic [bzf_pkg::TOL_W-1:0]     cfg_wdata
);
    import bzf_pkg::*;

    localparam int CW    = COORD_W + GUARD_BITS;
    localparam int LW    = $clog2(MAX_DEPTH + 1);
    localparam int SW    = LW;
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ROW_W = NCOORD * CW + LW;
    localparam logic [LW-1:0] LVL_MAX = LW'(MAX_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EMIT0 = 3'd1;
    localparam logic [2:0] ST_NODE  = 3'd2;
    localparam logic [2:0] ST_TEST  = 3'd3;
    localparam logic [2:0] ST_FLAT  = 3'd4;
    localparam logic [2:0] ST_POPW  = 3'd5;
    localparam logic [2:0] ST_SPLIT = 3'd6;
    localparam logic [2:0] ST_PUSH  = 3'd7;

    // de casteljau steps for one axis
    localparam logic [2:0] SP_M  = 3'd0;
    localparam logic [2:0] SP_L1 = 3'd1;
    localparam logic [2:0] SP_R2 = 3'd2;
    localparam logic [2:0] SP_L2 = 3'd3;
    localparam logic [2:0] SP_R1 = 3'd4;
    localparam logic [2:0] SP_L3 = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [TOL_W-1:0]       tol_reg, tol_next;
    logic signed [CW-1:0]   cur_reg [NCOORD];
    logic signed [CW-1:0]   cur_next [NCOORD];
    logic signed [CW-1:0]   rb_reg [NCOORD];
    logic signed [CW-1:0]   rb_next [NCOORD];
    logic signed [CW-1:0]   tm_reg, tm_next;
    logic [LW-1:0]          level_reg, level_next;
    logic [SW-1:0]          sp_reg, sp_next;
    logic [2:0]             sub_reg, sub_next;
    logic                   axis_reg, axis_next;
    logic                   mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]       mdata_reg, mdata_next;
    logic                   mlast_reg, mlast_next;

    logic                   out_free;
    logic signed [CW-1:0]   op_a, op_b, mid;
    logic signed [CW:0]     mid_sum;
    logic [LW-1:0]          lvl_inc;
    logic [SW-1:0]          sp_dec;
    logic [ROW_W-1:0]       push_row, pop_row;
    logic                   flat_start;
    bzf_flat_st_t           flat_st;

    function automatic logic [COORD_W-1:0] to_out(input logic signed [CW-1:0] c);
        return c[CW-1:GUARD_BITS];
    endfunction

    assign out_free = !mvalid_reg || m_tready;
    assign lvl_inc  = level_reg + 1'b1;
    assign sp_dec   = sp_reg - 1'b1;

    // shared midpoint adder, floor halving
    always_comb begin
        unique case (sub_reg)
            SP_M: begin
                op_a = cur_reg[{2'd1, axis_reg}];
                op_b = cur_reg[{2'd2, axis_reg}];
            end
            SP_L1: begin
                op_a = cur_reg[{2'd0, axis_reg}];
                op_b = cur_reg[{2'd1, axis_reg}];
            end
            SP_R2: begin
                op_a = cur_reg[{2'd2, axis_reg}];
                op_b = cur_reg[{2'd3, axis_reg}];
            end
            SP_L2: begin
                op_a = cur_reg[{2'd1, axis_reg}];
                op_b = tm_reg;
            end
            SP_R1: begin
                op_a = tm_reg;
                op_b = rb_reg[{2'd2, axis_reg}];
            end
            SP_L3: begin
                op_a = cur_reg[{2'd2, axis_reg}];
                op_b = rb_reg[{2'd1, axis_reg}];
            end
            default: begin
                op_a = cur_reg[0];
                op_b = cur_reg[0];
            end
        endcase
        mid_sum = (CW + 1)'(op_a) + (CW + 1)'(op_b);
        mid     = mid_sum[CW:1];
    end

    always_comb begin
        for (int k = 0; k < NCOORD; k++) begin
            push_row[k * CW +: CW] = rb_reg[k];
        end
        push_row[NCOORD * CW +: LW] = lvl_inc;
    end

    always_comb begin
        state_next  = state_reg;
        tol_next    = cfg_wen ? cfg_wdata : tol_reg;
        cur_next    = cur_reg;
        rb_next     = rb_reg;
        tm_next     = tm_reg;
        level_next  = level_reg;
        sp_next     = sp_reg;
        sub_next    = sub_reg;
        axis_next   = axis_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        flat_start  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int k = 0; k < NCOORD; k++) begin
                        cur_next[k] = CW'($signed(s_tdata[k * COORD_W +: COORD_W]))
                                      <<< GUARD_BITS;
                    end
                    level_next = '0;
                    sp_next    = '0;
                    state_next = ST_EMIT0;
                end
            end
            ST_EMIT0: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {to_out(cur_reg[1]), to_out(cur_reg[0])};
                    mlast_next  = 1'b0;
                    state_next  = ST_NODE;
                end
            end
            ST_NODE: begin
                if (level_reg == LVL_MAX) begin
                    state_next = ST_FLAT;
                end else begin
                    flat_start = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (flat_st.done) begin
                    if (flat_st.flat) begin
                        state_next = ST_FLAT;
                    end else begin
                        sub_next   = SP_M;
                        axis_next  = 1'b0;
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_FLAT: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {to_out(cur_reg[7]), to_out(cur_reg[6])};
                    mlast_next  = (sp_reg == '0);
                    if (sp_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        sp_next    = sp_dec;
                        state_next = ST_POPW;
                    end
                end
            end
            ST_POPW: begin
                for (int k = 0; k < NCOORD; k++) begin
                    cur_next[k] = pop_row[k * CW +: CW];
                end
                level_next = pop_row[NCOORD * CW +: LW];
                state_next = ST_NODE;
            end
            ST_SPLIT: begin
                sub_next = sub_reg + 3'd1;
                unique case (sub_reg)
                    SP_M:  tm_next = mid;
                    SP_L1: cur_next[{2'd1, axis_reg}] = mid;
                    SP_R2: begin
                        rb_next[{2'd2, axis_reg}] = mid;
                        rb_next[{2'd3, axis_reg}] = cur_reg[{2'd3, axis_reg}];
                    end
                    SP_L2: cur_next[{2'd2, axis_reg}] = mid;
                    SP_R1: rb_next[{2'd1, axis_reg}] = mid;
                    SP_L3: begin
                        cur_next[{2'd3, axis_reg}] = mid;
                        rb_next[{2'd0, axis_reg}]  = mid;
                        sub_next = SP_M;
                        if (axis_reg) begin
                            state_next = ST_PUSH;
                        end else begin
                            axis_next = 1'b1;
                        end
                    end
                    default: sub_next = SP_M;
                endcase
            end
            ST_PUSH: begin
                sp_next    = sp_reg + 1'b1;
                level_next = lvl_inc;
                state_next = ST_NODE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tol_reg    <= TOL_RESET;
            level_reg  <= '0;
            sp_reg     <= '0;
            sub_reg    <= SP_M;
            axis_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tol_reg    <= tol_next;
            level_reg  <= level_next;
            sp_reg     <= sp_next;
            sub_reg    <= sub_next;
            axis_reg   <= axis_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        rb_reg    <= rb_next;
        tm_reg    <= tm_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    bzf_stack #(
        .DEPTH (MAX_DEPTH),
        .AW    (AW),
        .DW    (ROW_W)
    ) u_stack (
        .aclk  (aclk),
        .we    (state_reg == ST_PUSH),
        .waddr (sp_reg[AW-1:0]),
        .wdata (push_row),
        .re    ((state_reg == ST_FLAT) && (sp_reg != '0)),
        .raddr (sp_dec[AW-1:0]),
        .rdata (pop_row)
    );

    bzf_flat #(
        .CW (CW)
    ) u_flat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (flat_start),
        .tol     (tol_reg),
        .coord   (cur_reg),
        .status  (flat_st)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    // stack depth never exceeds the memory size
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SW'(MAX_DEPTH))
        else $error("pending stack overflow");

    // a push only happens below the depth bound and with room on the stack
    a_push_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |-> (sp_reg <= level_reg) && (level_reg < LVL_MAX))
        else $error("push beyond depth bound");

    // the flatness verdict arrives only while the walk waits for it
    a_flat_done: assert property (@(posedge aclk) disable iff (!aresetn)
        flat_st.done |-> (state_reg == ST_TEST))
        else $error("flatness result outside test state");

    // a pop always follows a decrement of the stack pointer
    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POPW) |-> ($past(sp_reg) == sp_reg + 1'b1))
        else $error("pop without stack decrement");

endmodule
